// ----- sv/swa_pkg.sv -----
// Shared constants and types for the sliding window average block.
`timescale 1ns / 1ps
`default_nettype none
package swa_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int CFG_W            = 9;
	localparam int CFG_LEN_RESET    = 16;
	localparam int WINDOW_DEPTH_DEF = 256;

	typedef struct packed {
		logic busy;
		logic done;
	} swa_div_stat_t;

endpackage
`default_nettype wire

// ----- sv/swa_store.sv -----
// Sample ring memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module swa_store #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- sv/swa_divider.sv -----
// Iterative restoring divider: signed sum by unsigned length, truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module swa_divider #(
	parameter int SUM_W = 25,
	parameter int LEN_W = 9
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [SUM_W-1:0]     dividend,
	input  wire logic        [LEN_W-1:0]     divisor,
	output swa_pkg::swa_div_stat_t           stat,
	output logic signed [swa_pkg::SAMPLE_W-1:0] quotient
);
	import swa_pkg::*;

	localparam int CNT_W = $clog2(SUM_W);

	logic [SUM_W-1:0] dq_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] div_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [LEN_W:0]   rem_sh;
	logic [LEN_W:0]   rem_sub;
	logic             ge;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] q_signed;

	assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign rem_sh  = {rem_q, dq_q[SUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign ge      = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= mag;
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], ge};
		end
	end

	assign q_signed  = neg_q ? (~dq_q + SUM_W'(1)) : dq_q;
	assign quotient  = q_signed[SAMPLE_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

// ----- sv/sliding_window_average.sv -----
// Top level of the sliding window average filter.
// Each sample replaces the oldest entry of a ring memory, a running sum is updated,
// and the mean of the last window_length samples, truncated toward zero, is returned.
// One sample is in flight at a time. The old entry is read as the sample is accepted,
// the sum is updated and the memory written in ST_UPDATE, then the divider forms
// one quotient bit per cycle. A write to cfg_data clears the window at once;
// entries not written since then read as zero.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_average #(
	parameter int WINDOW_DEPTH = swa_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [swa_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // [15:0] sample
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [swa_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // [15:0] average
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [swa_pkg::CFG_W-1:0]     cfg_data       // [8:0] window_length
);
	import swa_pkg::*;

	localparam int POS_W     = $clog2(WINDOW_DEPTH);
	localparam int LEN_W     = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W     = SAMPLE_W + POS_W + 1;
	localparam int LEN_RESET = (CFG_LEN_RESET > WINDOW_DEPTH) ? WINDOW_DEPTH : CFG_LEN_RESET;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE
	} state_t;

	state_t                  state_q;
	logic [LEN_W-1:0]        len_q;
	logic [POS_W-1:0]        pos_q;
	logic                    wrapped_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    out_valid_q;
	logic [SAMPLE_W-1:0]     out_data_q;
	logic [SAMPLE_W-1:0]     sample_q;

	logic                    in_accept;
	logic                    cfg_write;
	logic [LEN_W-1:0]        cfg_len;
	logic [SAMPLE_W-1:0]     rd_data;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] sum_next;
	logic                    pos_last;
	logic                    div_start;
	swa_div_stat_t           div_stat;
	logic [SAMPLE_W-1:0]     div_quot;
	logic                    out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_write     = cfg_valid && cfg_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_len = LEN_W'(1);
		end else if (32'(cfg_data) > 32'(WINDOW_DEPTH)) begin
			cfg_len = LEN_W'(WINDOW_DEPTH);
		end else begin
			cfg_len = LEN_W'(cfg_data);
		end
	end

	assign old_ext   = wrapped_q ? SUM_W'(signed'(rd_data)) : '0;
	assign new_ext   = SUM_W'(signed'(sample_q));
	assign sum_next  = sum_q - old_ext + new_ext;
	assign pos_last  = (LEN_W'(pos_q) + LEN_W'(1)) == len_q;
	assign div_start = (state_q == ST_UPDATE);
	assign out_load  = (state_q == ST_DIVIDE) && div_stat.done
		&& (!out_valid_q || m_axis_tready);

	swa_store #(
		.DEPTH  (WINDOW_DEPTH),
		.ADDR_W (POS_W),
		.DATA_W (SAMPLE_W)
	) u_store (
		.clk     (clk),
		.wr_en   (div_start),
		.wr_addr (pos_q),
		.wr_data (sample_q),
		.rd_en   (in_accept),
		.rd_addr (pos_q),
		.rd_data (rd_data)
	);

	swa_divider #(
		.SUM_W (SUM_W),
		.LEN_W (LEN_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (len_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= LEN_W'(LEN_RESET);
			pos_q       <= '0;
			wrapped_q   <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= div_quot;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					sum_q <= sum_next;
					if (pos_last) begin
						pos_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_write) begin
				len_q     <= cfg_len;
				pos_q     <= '0;
				wrapped_q <= 1'b0;
				sum_q     <= '0;
			end
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !s_axis_tready)
		else $error("A second sample was accepted while one was in flight.");

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(pos_q) < len_q)
		else $error("The write position left the window.");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) && (32'(len_q) <= 32'(WINDOW_DEPTH)))
		else $error("The effective window length is out of range.");

	a_div_done_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_stat.busy && !div_stat.done)
		else $error("The divider did not start after the sum update.");

endmodule
`default_nettype wire

// ----- verif/sliding_window_average_tb.sv -----
// Self-checking testbench for the sliding window average filter.
`timescale 1ns / 1ps
module sliding_window_average_tb;
	import swa_pkg::*;

	localparam int WINDOW_DEPTH = WINDOW_DEPTH_DEF;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE       = 40;

	localparam logic [SAMPLE_W-1:0] DIRECTED_RESET[10] = '{16'h7FFF, 16'h8000, 16'h0000,
		16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h7FFE, 16'h8001, 16'h0002};
	localparam logic [SAMPLE_W-1:0] DIRECTED_PAIR[8] = '{16'h7FFF, 16'h7FFF, 16'h8000,
		16'h8000, 16'hFFFF, 16'hFFFE, 16'h0001, 16'h0000};

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_axis_tdata;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data      = '0;

	logic [SAMPLE_W-1:0] sample_backlog[$];
	logic [SAMPLE_W-1:0] avg_due[$];
	logic                sample_taken  = 1'b0;
	logic                calm          = 1'b0;
	int                  hold_epoch    = 0;
	int                  hold_seen     = 0;
	int                  hold_left     = 0;
	int                  stall_cycles  = 0;
	int                  mismatch_count = 0;

	logic signed [SAMPLE_W-1:0] win_store[WINDOW_DEPTH];
	logic signed [24:0]         win_sum;
	int unsigned                win_pos;
	logic [CFG_W-1:0]           win_len;

	sliding_window_average #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void window_restart(input logic [CFG_W-1:0] len);
		win_len = len;
		foreach (win_store[i]) win_store[i] = '0;
		win_sum = '0;
		win_pos = 0;
	endfunction

	function automatic logic [SAMPLE_W-1:0] window_push(input logic [SAMPLE_W-1:0] raw);
		int unsigned n;
		int unsigned p;
		int quotient;
		n = win_len;
		if (n == 0) n = 1;
		if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
		p = (win_pos >= n) ? 0 : win_pos;
		win_sum = win_sum - win_store[p] + $signed(raw);
		win_store[p] = raw;
		quotient = int'(win_sum) / int'(n);
		p++;
		win_pos = (p >= n) ? 0 : p;
		return quotient[SAMPLE_W-1:0];
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Sender: a new sample is offered only once the previous transaction has completed.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || sample_taken)) begin
			if (sample_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
				s_axis_tdata  <= sample_backlog.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_seen != hold_epoch) begin
			hold_seen     <= hold_epoch;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && (calm || $urandom_range(0, 99) >= 15);
		end
	end

	always @(posedge clk) begin
		logic [SAMPLE_W-1:0] due;
		logic                result_taken;
		logic                cfg_taken;
		sample_taken = s_axis_tvalid && s_axis_tready;
		result_taken = m_axis_tvalid && m_axis_tready;
		cfg_taken    = cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_taken) window_restart(cfg_data);
			if (sample_taken) avg_due.push_back(window_push(s_axis_tdata));
			if (result_taken) begin
				if (avg_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected average %0d", $signed(m_axis_tdata)));
				end else begin
					due = avg_due.pop_front();
					if (m_axis_tdata !== due)
						flag_mismatch($sformatf("average got %0d expected %0d",
							$signed(m_axis_tdata), $signed(due)));
				end
			end
			stall_cycles = (sample_taken || result_taken || cfg_taken) ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog expired with %0d averages outstanding", avg_due.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		@(negedge clk);
		while (sample_backlog.size() != 0 || s_axis_tvalid || avg_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_window_length(input logic [CFG_W-1:0] len);
		wait_drained();
		repeat (SETTLE) @(negedge clk);
		cfg_data  <= len;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random(input int count);
		logic [SAMPLE_W-1:0] v;
		repeat (count) begin
			case ($urandom_range(0, 7))
				0: v = 16'h7FFF;
				1: v = 16'h8000;
				2: v = 16'($urandom_range(0, 3)) - 16'd2;
				3: v = {1'b0, 15'($urandom)};
				default: v = 16'($urandom);
			endcase
			sample_backlog.push_back(v);
		end
	endtask

	initial begin
		window_restart(CFG_W'(CFG_LEN_RESET));
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Warm-up at the reset window length.
		foreach (DIRECTED_RESET[i]) sample_backlog.push_back(DIRECTED_RESET[i]);

		// Two-entry window: full-scale sums and truncation of a negative odd sum.
		write_window_length(9'd2);
		foreach (DIRECTED_PAIR[i]) sample_backlog.push_back(DIRECTED_PAIR[i]);
		queue_random(30);

		write_window_length(9'd1);
		queue_random(30);
		write_window_length(9'd0);
		queue_random(20);
		write_window_length(9'd256);
		queue_random(280);
		write_window_length(9'd511);
		queue_random(60);
		write_window_length(9'd257);
		queue_random(20);
		write_window_length(9'd255);
		queue_random(40);

		write_window_length(9'd3);
		calm <= 1'b1;
		queue_random(100);
		wait_drained();
		calm <= 1'b0;

		repeat (3) begin
			write_window_length(CFG_W'($urandom_range(1, 511)));
			queue_random(30);
		end

		// Long output stall while samples are still offered at the input.
		write_window_length(9'd16);
		queue_random(80);
		@(posedge clk);
		hold_epoch++;

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/swa_pkg.sv
sv/swa_store.sv
sv/swa_divider.sv
sv/sliding_window_average.sv
verif/sliding_window_average_tb.sv
